>>> hw/rtl/pairwise_max_sum_edge_update_unit_defines.svh
// Assertion macros shared by the edge update unit
`ifndef PAIRWISE_MAX_SUM_EDGE_UPDATE_UNIT_DEFINES_SVH
`define PAIRWISE_MAX_SUM_EDGE_UPDATE_UNIT_DEFINES_SVH

// Same-cycle implication, clocked on clk, off during reset
`define PMSEU_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pmseu assertion failed");

// Next-cycle implication, clocked on clk, off during reset
`define PMSEU_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pmseu assertion failed");

`endif

>>> hw/rtl/pmseu_pkg.sv
// Types and constants of the pairwise max-sum edge update unit
`default_nettype none
package pmseu_pkg;
	localparam int NODE_STATES_DEF = 8;
	localparam int SLOTS_DEF       = 16;
	localparam int CMD_DEPTH       = 2;
	localparam int RES_DEPTH       = 2;
	localparam logic [30:0] LAMBDA_RST = 31'd65536;

	typedef struct packed {
		logic [3:0]         slot;
		logic [2:0]         index;
		logic signed [31:0] belief_a;
		logic signed [31:0] belief_b;
		logic               init_slot;
		logic               last;
	} in_item_t;

	typedef struct packed {
		logic [2:0]         out_index;
		logic signed [31:0] new_belief_a;
		logic signed [31:0] new_belief_b;
		logic               out_last;
	} out_item_t;

	typedef struct packed {
		in_item_t item;
		logic     slot_ok;
		logic     index_ok;
	} cmd_t;
endpackage
`default_nettype wire

>>> hw/rtl/pmseu_fifo.sv
// Small register FIFO used for the command and result queues
`default_nettype none
module pmseu_fifo #(
	parameter int W     = 8,
	parameter int DEPTH = 2
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	output logic         full,
	input  logic [W-1:0] wdata,
	input  logic         pop,
	output logic         empty,
	output logic [W-1:0] rdata
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [W-1:0]  mem_q [DEPTH];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [CW-1:0] cnt_q;
	logic          do_push;
	logic          do_pop;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end
endmodule
`default_nettype wire

>>> hw/rtl/pmseu_front.sv
// Front end: accepts requests, classifies slot and index, queues commands
`default_nettype none
module pmseu_front #(
	parameter int NODE_STATES = 8,
	parameter int SLOTS       = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  pmseu_pkg::in_item_t in_item,
	input  logic                clearing,
	input  logic                cmd_pop,
	output logic                cmd_empty,
	output pmseu_pkg::cmd_t     cmd
);
	import pmseu_pkg::*;

	cmd_t                 cmd_in;
	logic                 q_full;
	logic [$bits(cmd_t)-1:0] cmd_raw;

	always_comb begin
		cmd_in          = '0;
		cmd_in.item     = in_item;
		cmd_in.slot_ok  = (int'(in_item.slot) < SLOTS);
		cmd_in.index_ok = (int'(in_item.index) < NODE_STATES);
	end

	// hold off requests while the matrix store is being cleared
	assign full = q_full || clearing;
	assign cmd  = cmd_t'(cmd_raw);

	pmseu_fifo #(
		.W    ($bits(cmd_t)),
		.DEPTH(CMD_DEPTH)
	) u_cmd_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push && !clearing),
		.full  (q_full),
		.wdata (cmd_in),
		.pop   (cmd_pop),
		.empty (cmd_empty),
		.rdata (cmd_raw)
	);
endmodule
`default_nettype wire

>>> hw/rtl/pmseu_back.sv
// Back end: matrix store, init and update sweeps, result emission
`default_nettype none
`include "pairwise_max_sum_edge_update_unit_defines.svh"
module pmseu_back #(
	parameter int NODE_STATES = 8,
	parameter int SLOTS       = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [30:0]          cfg_wdata,
	input  logic                 cmd_empty,
	input  pmseu_pkg::cmd_t      cmd,
	output logic                 cmd_pop,
	output logic                 clearing,
	output logic                 res_push,
	input  logic                 res_full,
	output pmseu_pkg::out_item_t res_item
);
	import pmseu_pkg::*;

	localparam int MAT   = NODE_STATES * NODE_STATES;
	localparam int DEPTH = SLOTS * MAT;
	localparam int AW    = $clog2(DEPTH);
	localparam int IW    = $clog2(NODE_STATES);
	localparam int EMIT  = (NODE_STATES < 8) ? NODE_STATES : 8;

	typedef enum logic [7:0] {
		S_CLEAR = 8'b0000_0001,
		S_IDLE  = 8'b0000_0010,
		S_INIT  = 8'b0000_0100,
		S_P1    = 8'b0000_1000,
		S_D1    = 8'b0001_0000,
		S_P2    = 8'b0010_0000,
		S_D2    = 8'b0100_0000,
		S_EMIT  = 8'b1000_0000
	} state_t;

	function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
		logic signed [31:0] r;
		if (v > 34'sh0_7FFF_FFFF) begin
			r = 32'sh7FFF_FFFF;
		end else if (v < -34'sh0_8000_0000) begin
			r = -32'sh8000_0000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	state_t             state_q;
	logic [30:0]        lambda_q;
	logic [AW-1:0]      addr_q;
	logic [AW-1:0]      base_q;
	logic [IW-1:0]      i_q;
	logic [IW-1:0]      j_q;
	logic [IW-1:0]      k_q;
	logic               upd_q;

	logic signed [31:0] mem [DEPTH];
	logic signed [31:0] buf_a_q [NODE_STATES];
	logic signed [31:0] buf_b_q [NODE_STATES];
	logic signed [31:0] max_a_q [NODE_STATES];
	logic signed [31:0] max_b_q [NODE_STATES];

	logic               v_s1, v_s2;
	logic               p2_s1, p2_s2;
	logic [IW-1:0]      i_s1, j_s1, i_s2, j_s2;
	logic [AW-1:0]      addr_s1, addr_s2;
	logic signed [31:0] rd_s1;
	logic signed [31:0] w_s2;

	logic               issue;
	logic               drained;
	logic               cell_end;
	logic               mem_we;
	logic [AW-1:0]      mem_waddr;
	logic signed [31:0] mem_wdata;
	logic signed [31:0] neg_lambda;
	logic signed [33:0] m_x, a_x, b_x, s_x;
	logic [AW-1:0]      slot_base;

	assign clearing   = (state_q == S_CLEAR);
	assign cmd_pop    = (state_q == S_IDLE) && !cmd_empty;
	assign issue      = (state_q == S_P1) || (state_q == S_P2);
	assign drained    = !v_s1 && !v_s2;
	assign cell_end   = (i_q == IW'(NODE_STATES - 1)) && (j_q == IW'(NODE_STATES - 1));
	assign neg_lambda = -$signed({1'b0, lambda_q});
	assign slot_base  = AW'(int'(cmd.item.slot) * MAT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lambda_q <= LAMBDA_RST;
		end else if (cfg_we) begin
			lambda_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			addr_q  <= '0;
			base_q  <= '0;
			i_q     <= '0;
			j_q     <= '0;
			k_q     <= '0;
			upd_q   <= 1'b0;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					addr_q <= addr_q + 1'b1;
					if (addr_q == AW'(DEPTH - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (cmd_pop) begin
						base_q <= slot_base;
						addr_q <= slot_base;
						i_q    <= '0;
						j_q    <= '0;
						upd_q  <= cmd.item.last;
						if (cmd.slot_ok && cmd.item.init_slot) begin
							state_q <= S_INIT;
						end else if (cmd.slot_ok && cmd.item.last) begin
							state_q <= S_P1;
						end
					end
				end
				S_INIT, S_P1, S_P2: begin
					if (cell_end) begin
						addr_q <= base_q;
						i_q    <= '0;
						j_q    <= '0;
						unique case (state_q)
							S_INIT:  state_q <= upd_q ? S_P1 : S_IDLE;
							S_P1:    state_q <= S_D1;
							default: state_q <= S_D2;
						endcase
					end else begin
						addr_q <= addr_q + 1'b1;
						if (j_q == IW'(NODE_STATES - 1)) begin
							j_q <= '0;
							i_q <= i_q + 1'b1;
						end else begin
							j_q <= j_q + 1'b1;
						end
					end
				end
				S_D1: begin
					if (drained) begin
						state_q <= S_P2;
					end
				end
				S_D2: begin
					if (drained) begin
						k_q     <= '0;
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (!res_full) begin
						k_q <= k_q + 1'b1;
						if (k_q == IW'(EMIT - 1)) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// one write port: clear and init sweeps, or the update pipeline
	always_comb begin
		mem_we    = (state_q == S_CLEAR) || (state_q == S_INIT) || v_s2;
		mem_waddr = v_s2 ? addr_s2 : addr_q;
		if (v_s2) begin
			mem_wdata = w_s2;
		end else if ((state_q == S_INIT) && (i_q == j_q)) begin
			mem_wdata = neg_lambda;
		end else begin
			mem_wdata = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rd_s1 <= mem[addr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1;
		end
	end

	always_comb begin
		m_x = 34'(rd_s1);
		a_x = 34'(buf_a_q[i_s1]);
		b_x = 34'(buf_b_q[j_s1]);
		s_x = p2_s1 ? (m_x - a_x - b_x) : (m_x + a_x + b_x);
	end

	always_ff @(posedge clk) begin
		i_s1    <= i_q;
		j_s1    <= j_q;
		addr_s1 <= addr_q;
		p2_s1   <= (state_q == S_P2);
		i_s2    <= i_s1;
		j_s2    <= j_s1;
		addr_s2 <= addr_s1;
		p2_s2   <= p2_s1;
		w_s2    <= sat32(s_x);
	end

	// row and column maxima track the first pass write-back
	always_ff @(posedge clk) begin
		if (v_s2 && !p2_s2) begin
			if ((j_s2 == '0) || (w_s2 > max_a_q[i_s2])) begin
				max_a_q[i_s2] <= w_s2;
			end
			if ((i_s2 == '0) || (w_s2 > max_b_q[j_s2])) begin
				max_b_q[j_s2] <= w_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop && cmd.index_ok) begin
			buf_a_q[IW'(cmd.item.index)] <= cmd.item.belief_a;
			buf_b_q[IW'(cmd.item.index)] <= cmd.item.belief_b;
		end else if ((state_q == S_D1) && drained) begin
			for (int n = 0; n < NODE_STATES; n++) begin
				buf_a_q[n] <= max_a_q[n] >>> 1;
				buf_b_q[n] <= max_b_q[n] >>> 1;
			end
		end
	end

	assign res_push = (state_q == S_EMIT);
	always_comb begin
		res_item              = '0;
		res_item.out_index    = 3'(k_q);
		res_item.new_belief_a = buf_a_q[k_q];
		res_item.new_belief_b = buf_b_q[k_q];
		res_item.out_last     = (k_q == IW'(EMIT - 1));
	end

	`PMSEU_ASSERT_IMPL(a_idle_drained, state_q == S_IDLE, !v_s1 && !v_s2)
	`PMSEU_ASSERT_NEXT(a_emit_hold, (state_q == S_EMIT) && res_full, (state_q == S_EMIT) && $stable(k_q))
	`PMSEU_ASSERT_IMPL(a_write_in_range, mem_we, mem_waddr <= AW'(DEPTH - 1))
endmodule
`default_nettype wire

>>> hw/rtl/pairwise_max_sum_edge_update_unit.sv
// Load item: registered in a command FIFO; one load accepted per cycle while idle.
// Update item (last): an init sweep if requested, then two update sweeps,
// then min(N,8) results, one per cycle while the result queue is not full.
// Reset: arst_n clears control; a clearing pass of SLOTS*N*N cells (1024 by default)
// zeroes the matrix store, with full held high until it is done.
`default_nettype none
module pairwise_max_sum_edge_update_unit #(
	parameter int NODE_STATES = pmseu_pkg::NODE_STATES_DEF,
	parameter int SLOTS       = pmseu_pkg::SLOTS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [30:0]          cfg_wdata,
	input  logic                 push,
	output logic                 full,
	input  pmseu_pkg::in_item_t  in_item,
	output logic                 empty,
	input  logic                 pop,
	output pmseu_pkg::out_item_t out_item
);
	import pmseu_pkg::*;

	cmd_t      cmd;
	logic      cmd_empty;
	logic      cmd_pop;
	logic      clearing;
	logic      res_push;
	logic      res_full;
	out_item_t res_item;
	logic [$bits(out_item_t)-1:0] res_raw;

	assign out_item = out_item_t'(res_raw);

	pmseu_front #(
		.NODE_STATES(NODE_STATES),
		.SLOTS      (SLOTS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.in_item  (in_item),
		.clearing (clearing),
		.cmd_pop  (cmd_pop),
		.cmd_empty(cmd_empty),
		.cmd      (cmd)
	);

	pmseu_back #(
		.NODE_STATES(NODE_STATES),
		.SLOTS      (SLOTS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.cmd_empty(cmd_empty),
		.cmd      (cmd),
		.cmd_pop  (cmd_pop),
		.clearing (clearing),
		.res_push (res_push),
		.res_full (res_full),
		.res_item (res_item)
	);

	pmseu_fifo #(
		.W    ($bits(out_item_t)),
		.DEPTH(RES_DEPTH)
	) u_res_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (res_push),
		.full  (res_full),
		.wdata (res_item),
		.pop   (pop),
		.empty (empty),
		.rdata (res_raw)
	);
endmodule
`default_nettype wire
